FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros for the RTL file that carries concurrent checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk_sig, rst_sig, ante, cons) \
  lbl: assert property (@(posedge clk_sig) disable iff (rst_sig) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: hdl/mbcrc_pkg.sv
// ----------------------------------------------------------------------------
// mbcrc_pkg
// Types and constants for the Modbus RTU response frame checker.
// ----------------------------------------------------------------------------
package mbcrc_pkg;

  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'hA001;
  localparam int          CRC_BYTES  = 5;
  localparam int          FRAME_BYTES = 7;
  localparam logic [2:0]  POS_IDLE   = 3'd7;
  localparam logic [2:0]  POS_VAL_HI = 3'd3;
  localparam logic [2:0]  POS_VAL_LO = 3'd4;
  localparam logic [2:0]  POS_CRC_LO = 3'd5;
  localparam logic [2:0]  POS_LAST   = 3'(FRAME_BYTES - 1);
  localparam logic [2:0]  POS_CRC_END = 3'(CRC_BYTES);

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
  } byte_item_t;

  typedef struct packed {
    logic [15:0] reading_value;
    logic        crc_ok;
    logic [15:0] computed_crc;
    logic [15:0] received_crc;
  } result_item_t;

endpackage

FILE: hdl/modbus_response_frame_checker_unit.sv
// ----------------------------------------------------------------------------
// modbus_response_frame_checker_unit
// Takes the seven bytes of a Modbus RTU read-input-register response, one
// byte per transfer, with frame_start set on the first byte. A CRC-16 runs
// over bytes 0 to 4, bytes 3 and 4 give the register value, and bytes 5 and 6
// give the received CRC. The seventh byte yields one result with the value,
// both CRCs and a match flag. Bytes outside a frame give nothing, and a
// frame_start byte always restarts the frame. Each byte passes an input
// register and the CRC and field logic into the result register, so a
// byte is accepted every cycle; only a stalled result register holding
// back a waiting byte slows the input.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module modbus_response_frame_checker_unit
  import mbcrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  output logic         byte_ready,
  input  byte_item_t   byte_item,
  output logic         result_valid,
  input  logic         result_ready,
  output result_item_t result_item
);

  logic         stage_valid;
  byte_item_t   stage_item;
  logic         fire;

  logic [2:0]   byte_position;
  logic [15:0]  running_crc;
  logic [15:0]  value_reg;
  logic [7:0]   crc_low_byte;

  logic         active;
  logic [2:0]   pos;
  logic [15:0]  crc_base;
  logic [15:0]  crc_new;
  logic [15:0]  value_next;
  logic [7:0]   crc_low_next;
  logic [15:0]  got_crc;
  logic         last_byte;

  assign fire       = stage_valid && (!result_valid || result_ready);
  assign byte_ready = !stage_valid || fire;

  assign active   = stage_item.frame_start || (byte_position != POS_IDLE);
  assign pos      = stage_item.frame_start ? 3'd0 : byte_position;
  assign crc_base = stage_item.frame_start ? CRC_INIT : running_crc;
  assign last_byte = fire && active && (pos == POS_LAST);
  assign got_crc  = {stage_item.rx_byte, crc_low_byte};

  mbcrc_crc_byte u_crc (
    .crc_in  (crc_base),
    .data    (stage_item.rx_byte),
    .crc_out (crc_new)
  );

  always_comb begin
    value_next   = stage_item.frame_start ? 16'h0000 : value_reg;
    crc_low_next = stage_item.frame_start ? 8'h00 : crc_low_byte;
    case (pos)
      POS_VAL_HI: value_next[15:8] = stage_item.rx_byte;
      POS_VAL_LO: value_next[7:0]  = stage_item.rx_byte;
      POS_CRC_LO: crc_low_next     = stage_item.rx_byte;
      default: ;
    endcase
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (byte_ready) begin
      stage_valid <= byte_valid;
    end
    if (byte_ready && byte_valid) begin
      stage_item <= byte_item;
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_IDLE;
      running_crc   <= CRC_INIT;
      value_reg     <= 16'h0000;
      crc_low_byte  <= 8'h00;
    end else if (fire && active) begin
      if (pos < POS_CRC_END) begin
        running_crc <= crc_new;
      end else begin
        running_crc <= crc_base;
      end
      value_reg    <= value_next;
      crc_low_byte <= crc_low_next;
      byte_position <= (pos == POS_LAST) ? POS_IDLE : pos + 3'd1;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (last_byte) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
    if (last_byte) begin
      result_item.reading_value <= value_reg;
      result_item.crc_ok        <= (running_crc == got_crc);
      result_item.computed_crc  <= running_crc;
      result_item.received_crc  <= got_crc;
    end
  end

  // Input is held back only by a waiting byte behind a stalled result.
  `ASSERT_IMPL(a_stall_cause, clk, rst, !byte_ready, stage_valid && result_valid && !result_ready)

  // A new result follows only the last byte of a frame.
  `ASSERT_IMPL(a_result_from_last, clk, rst, $rose(result_valid), $past(byte_position) == POS_LAST)

  // Once the last byte is taken the frame goes idle.
  `ASSERT_NEXT(a_idle_after_last, clk, rst, last_byte, byte_position == POS_IDLE && result_valid)

endmodule

FILE: hdl/mbcrc_crc_byte.sv
// ----------------------------------------------------------------------------
// mbcrc_crc_byte
// One whole-byte update of the Modbus CRC-16 (reflected polynomial 0xA001).
// ----------------------------------------------------------------------------
module mbcrc_crc_byte
  import mbcrc_pkg::*;
(
  input  logic [15:0] crc_in,
  input  logic [7:0]  data,
  output logic [15:0] crc_out
);

  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    // Eight bit steps, LSB first, unrolled.
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

FILE: tb/frame_result_checker.sv
// ----------------------------------------------------------------------------
// frame_result_checker
// Watches the byte and result channels of the Modbus response frame checker.
// Every accepted byte inside a frame updates a local copy of the frame state
// and CRC; each completed frame queues the result it should produce. Accepted
// results are compared field by field against the oldest queued result.
// ----------------------------------------------------------------------------
module frame_result_checker
  import mbcrc_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         byte_valid,
  input  logic         byte_ready,
  input  byte_item_t   byte_item,
  input  logic         result_valid,
  input  logic         result_ready,
  input  result_item_t result_item,
  output int           mismatches,
  output int           pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PRINT_CAP = 40;

  result_item_t expected_readings[$];
  logic [2:0]   next_pos;
  logic [15:0]  crc_acc;
  logic [15:0]  value_acc;
  logic [7:0]   crc_low;
  int           fail_tally = 0;

  function automatic logic [15:0] crc16_fold_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what);
    if (fail_tally < PRINT_CAP) begin
      $display("MISMATCH at %0t ns: %s", $time, what);
    end
    fail_tally++;
  endtask

  task automatic track_frame_byte(input byte_item_t it);
    logic [2:0]   pos;
    result_item_t r;
    if (it.frame_start) begin
      crc_acc   = CRC_INIT;
      value_acc = '0;
      crc_low   = '0;
      pos       = '0;
    end else if (next_pos == POS_IDLE) begin
      // Outside a frame, bytes without the start flag are dropped.
      return;
    end else begin
      pos = next_pos;
    end
    if (pos < POS_CRC_END) begin
      crc_acc = crc16_fold_byte(crc_acc, it.rx_byte);
    end
    case (pos)
      POS_VAL_HI: value_acc[15:8] = it.rx_byte;
      POS_VAL_LO: value_acc[7:0] = it.rx_byte;
      POS_CRC_LO: crc_low = it.rx_byte;
      default: ;
    endcase
    if (pos == POS_LAST) begin
      r.reading_value = value_acc;
      r.received_crc  = {it.rx_byte, crc_low};
      r.computed_crc  = crc_acc;
      r.crc_ok        = (crc_acc == r.received_crc);
      expected_readings.push_back(r);
      next_pos = POS_IDLE;
    end else begin
      next_pos = pos + 3'd1;
    end
  endtask

  task automatic check_reading(input result_item_t got);
    result_item_t want;
    if (expected_readings.size() == 0) begin
      report_mismatch($sformatf("result with none expected: %p", got));
      return;
    end
    want = expected_readings.pop_front();
    if (got.reading_value !== want.reading_value) begin
      report_mismatch($sformatf("reading_value %h, expected %h",
                                got.reading_value, want.reading_value));
    end
    if (got.crc_ok !== want.crc_ok) begin
      report_mismatch($sformatf("crc_ok %b, expected %b", got.crc_ok, want.crc_ok));
    end
    if (got.computed_crc !== want.computed_crc) begin
      report_mismatch($sformatf("computed_crc %h, expected %h",
                                got.computed_crc, want.computed_crc));
    end
    if (got.received_crc !== want.received_crc) begin
      report_mismatch($sformatf("received_crc %h, expected %h",
                                got.received_crc, want.received_crc));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      next_pos  = POS_IDLE;
      crc_acc   = CRC_INIT;
      value_acc = '0;
      crc_low   = '0;
    end else begin
      if (byte_valid && byte_ready) begin
        track_frame_byte(byte_item);
      end
      if (result_valid && result_ready) begin
        check_reading(result_item);
      end
    end
    mismatches <= fail_tally;
    pending    <= expected_readings.size();
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives Modbus response frames into the frame checker: a few hand-built
// frames first, then mostly well-formed frames with random content mixed with
// corrupted, truncated and restarted frames and stray bytes. Both channels
// stall at random, and once the result side holds off long enough to back up
// the input. Checking is done by frame_result_checker.
// ----------------------------------------------------------------------------
module tb
  import mbcrc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_TARGET = 950;
  localparam int IDLE_PCT     = 18;
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 8;
  localparam int STALL_LIMIT  = 2000;

  logic         clk;
  logic         rst;
  logic         byte_valid;
  logic         byte_ready;
  byte_item_t   byte_item;
  logic         result_valid;
  logic         result_ready;
  result_item_t result_item;
  int           mismatches;
  int           pending;

  bit calm;
  bit want_hold;
  bit hold_done;
  int frame_bytes;

  modbus_response_frame_checker_unit dut (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item)
  );

  frame_result_checker chk (
    .clk          (clk),
    .rst          (rst),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .byte_item    (byte_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result_item  (result_item),
    .mismatches   (mismatches),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // CRC over the five covered bytes, used to build frames that should pass.
  function automatic logic [15:0] frame_crc(input logic [7:0] fb [0:6]);
    logic [15:0] c;
    c = CRC_INIT;
    for (int k = 0; k < CRC_BYTES; k++) begin
      c ^= {8'h00, fb[k]};
      for (int j = 0; j < 8; j++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
    end
    return c;
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic s);
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      byte_valid <= 1'b0;
      @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= byte_item_t'{rx_byte: b, frame_start: s};
    @(posedge clk);
    while (!byte_ready) begin
      @(posedge clk);
    end
  endtask

  task automatic send_frame(input logic [7:0] fb [0:6], input int n);
    for (int k = 0; k < n; k++) begin
      send_byte(fb[k], k == 0);
    end
    frame_bytes += n;
  endtask

  // Result side: random stalls, plus one long hold-off while bytes keep coming.
  initial begin
    result_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (want_hold && !hold_done) begin
        hold_done = 1'b1;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        result_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Ends the run if no transfer happens on either channel for too long.
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || (byte_valid && byte_ready) || (result_valid && result_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    logic [7:0]  fb [0:6];
    logic [15:0] crc;
    int          kind;
    int          frame_no;
    rst         = 1'b1;
    byte_valid  = 1'b0;
    byte_item   = '0;
    calm        = 1'b0;
    want_hold   = 1'b0;
    frame_bytes = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // A byte without the start flag while idle must be ignored.
    send_byte(8'h00, 1'b0);
    fb = '{8'h11, 8'h04, 8'h02, 8'hAB, 8'hCD, 8'h00, 8'h00};
    crc = frame_crc(fb);
    fb[5] = crc[7:0];
    fb[6] = crc[15:8];
    send_frame(fb, 7);
    // Trailing byte after a complete frame.
    send_byte(8'h5A, 1'b0);
    // A partial frame cut off by a new start, then all-ones and all-zeros frames.
    fb = '{default: 8'hFF};
    send_frame(fb, 3);
    send_frame(fb, 7);
    fb = '{default: 8'h00};
    send_frame(fb, 7);

    for (frame_no = 0; frame_bytes < FRAME_TARGET; frame_no++) begin
      calm = (frame_no >= 40 && frame_no < 70);
      if (frame_no == 90) begin
        want_hold = 1'b1;
      end
      for (int i = 0; i < CRC_BYTES; i++) begin
        fb[i] = 8'($urandom_range(0, 255));
      end
      if ($urandom_range(0, 1) == 1) begin
        fb[1] = 8'h04;
        fb[2] = 8'h02;
      end
      crc = frame_crc(fb);
      fb[5] = crc[7:0];
      fb[6] = crc[15:8];
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
        send_frame(fb, 7);
      end else if (kind < 70) begin
        fb[$urandom_range(0, 6)] ^= 8'($urandom_range(1, 255));
        send_frame(fb, 7);
      end else if (kind < 78) begin
        fb[5] = 8'($urandom_range(0, 255));
        fb[6] = 8'($urandom_range(0, 255));
        send_frame(fb, 7);
      end else if (kind < 90) begin
        // Truncated frame; the next start flag restarts the frame.
        send_frame(fb, $urandom_range(1, 6));
      end else begin
        send_frame(fb, 7);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0);
      end
    end
    byte_valid <= 1'b0;

    repeat (2) @(posedge clk);
    while (pending != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
